// ===== rtl/core/mssd_pkg.sv =====
`default_nettype none

package mssd_pkg;

  localparam int DIGIT_COUNT = 6;
  localparam int POS_W       = 3;
  localparam int CODE_W      = 5;
  localparam int SEG_W       = 8;
  localparam int COM_W       = 6;
  localparam int MEAS_W      = 16;
  localparam int OP_W        = 2;

  // Operation codes carried on tuser
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_VOLT = 2'd1;
  localparam logic [OP_W-1:0] OP_AMP  = 2'd2;

  localparam logic [MEAS_W-1:0] VOLT_MAX_MV = 16'd34500;
  localparam logic [MEAS_W-1:0] AMP_MAX_MA  = 16'd3000;

  localparam logic [CODE_W-1:0] DP_CODE_OFFSET = 5'd10;
  localparam logic [COM_W-1:0]  COMMONS_OFF    = 6'h3f;
  localparam logic [POS_W-1:0]  LAST_POS       = POS_W'(DIGIT_COUNT - 1);

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [3:0]        bcd_t;

  // Three digit codes for one half of the display, most significant first
  typedef struct packed {
    code_t hi;
    code_t mid;
    code_t lo;
  } fmt_codes_t;

  // Segment pattern of a digit code; codes 10..19 add the decimal point
  function automatic logic [SEG_W-1:0] seg_pattern(input code_t code);
    logic [SEG_W-1:0] pat;
    unique case (code)
      5'd0:  pat = 8'h3f;
      5'd1:  pat = 8'h06;
      5'd2:  pat = 8'h5b;
      5'd3:  pat = 8'h4f;
      5'd4:  pat = 8'h66;
      5'd5:  pat = 8'h6d;
      5'd6:  pat = 8'h7d;
      5'd7:  pat = 8'h07;
      5'd8:  pat = 8'h7f;
      5'd9:  pat = 8'h6f;
      5'd10: pat = 8'hbf;
      5'd11: pat = 8'h86;
      5'd12: pat = 8'hdb;
      5'd13: pat = 8'hcf;
      5'd14: pat = 8'he6;
      5'd15: pat = 8'hed;
      5'd16: pat = 8'hfd;
      5'd17: pat = 8'h87;
      5'd18: pat = 8'hff;
      5'd19: pat = 8'hef;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mssd_fmt.sv =====
`default_nettype none

module mssd_fmt
  import mssd_pkg::*;
(
  input  wire logic              is_volt,
  input  wire logic [MEAS_W-1:0] measurement,
  output fmt_codes_t             codes
);

  // Reciprocals for constant division, exact over the clamped range
  localparam logic [17:0] RECIP_10    = 18'd52429;   // >> 19
  localparam logic [17:0] RECIP_100   = 18'd167773;  // >> 24
  localparam logic [17:0] RECIP_1000  = 18'd67109;   // >> 26
  localparam logic [17:0] RECIP_10000 = 18'd107375;  // >> 30

  logic [MEAS_W-1:0] limit;
  logic [MEAS_W-1:0] clamped;
  logic [MEAS_W:0]   x;
  logic [34:0]       p1, p2, p3, p4;
  logic [11:0]       q1;
  logic [8:0]        q2;
  logic [5:0]        q3;
  logic [1:0]        q4;
  logic [11:0]       q2x10;
  logic [8:0]        q3x10;
  logic [5:0]        q4x10;
  logic [11:0]       r0;
  logic [8:0]        r1;
  logic [5:0]        r2;
  bcd_t              d0, d1, d2;
  logic              wide, up, c1, c2;
  bcd_t              n1, n2, n3;

  always_comb begin
    limit   = is_volt ? VOLT_MAX_MV : AMP_MAX_MA;
    clamped = (measurement > limit) ? limit : measurement;
    x       = {1'b0, clamped} + (MEAS_W+1)'(5);

    p1 = 35'(x) * 35'(RECIP_10);
    p2 = 35'(x) * 35'(RECIP_100);
    p3 = 35'(x) * 35'(RECIP_1000);
    p4 = 35'(x) * 35'(RECIP_10000);
    q1 = p1[30:19];
    q2 = p2[32:24];
    q3 = p3[31:26];
    q4 = p4[31:30];

    // Decimal digits of the value in tens of units
    q2x10 = {q2, 3'b000} + {2'b00, q2, 1'b0};
    q3x10 = {q3, 3'b000} + {2'b00, q3, 1'b0};
    q4x10 = {1'b0, q4, 3'b000} + {3'b000, q4, 1'b0};
    r0 = q1 - q2x10;
    r1 = q2 - q3x10;
    r2 = q3 - q4x10;
    d0 = r0[3:0];
    d1 = r1[3:0];
    d2 = r2[3:0];

    // Ten volts and above: round the dropped digit up when it is above five
    wide = is_volt && (q4 != 2'd0);
    up   = (d0 > 4'd5);
    c1   = up && (d1 == 4'd9);
    n1   = c1 ? 4'd0 : d1 + {3'b000, up};
    c2   = c1 && (d2 == 4'd9);
    n2   = c2 ? 4'd0 : d2 + {3'b000, c1};
    n3   = {2'b00, q4} + {3'b000, c2};

    if (wide) begin
      codes.hi  = {1'b0, n3};
      codes.mid = {1'b0, n2} + DP_CODE_OFFSET;
      codes.lo  = {1'b0, n1};
    end else begin
      codes.hi  = {1'b0, d2} + DP_CODE_OFFSET;
      codes.mid = {1'b0, d1};
      codes.lo  = {1'b0, d0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/meter_seven_segment_scan_display.sv =====
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: operation; tdata: measurement
// m_*       out  m_tvalid/m_tready  tdata: segment_lines, common_lines
//
// A transaction passes two registers: it is held in the input register, then the formatter
// and scan logic load the display state, which is the result register, and m_tvalid rises
// when that register is loaded. A new transaction is taken every cycle while m_tready stays
// high.
// Reset clears the digit codes, the scan position and the segment lines and
// turns all commons off; no result is pending after reset.
// While a result waits on m_*, one more transaction is held in the input register.
module meter_seven_segment_scan_display
  import mssd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [MEAS_W-1:0] s_tdata,   // [15:0] measurement
  input  wire logic [OP_W-1:0]   s_tuser,   // [1:0] operation
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  output      logic [15:0]       m_tdata    // [7:0] segment_lines, [13:8] common_lines
);

  // Input register
  logic              in_valid;
  logic [OP_W-1:0]   in_op;
  logic [MEAS_W-1:0] in_meas;

  // Display state; segment_drive and common_drive form the result register
  code_t             digit_codes [DIGIT_COUNT];
  logic [POS_W-1:0]  scan_position;
  logic [SEG_W-1:0]  segment_drive;
  logic [COM_W-1:0]  common_drive;

  logic       advance;
  fmt_codes_t fmt_codes;

  // Move the held transaction on when the result slot is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign m_tdata  = {2'b00, common_drive, segment_drive};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_meas <= s_tdata;
    end
  end

  mssd_fmt u_fmt (
    .is_volt     (in_op == OP_VOLT),
    .measurement (in_meas),
    .codes       (fmt_codes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      scan_position <= '0;
      segment_drive <= '0;
      common_drive  <= COMMONS_OFF;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_codes[i] <= '0;
      end
    end else begin
      // Hold a stalled result, drop a drained one, load a new one on advance
      m_tvalid <= advance || (m_tvalid && !m_tready);
      if (advance) begin
        unique case (in_op)
          OP_TICK: begin
            // Drive the digit at the scan position and step to the next one
            if (scan_position <= LAST_POS) begin
              segment_drive <= seg_pattern(digit_codes[scan_position]);
              common_drive  <= ~(COM_W'(1) << scan_position);
              scan_position <= (scan_position == LAST_POS) ? '0 : scan_position + 1'b1;
            end else begin
              segment_drive <= '0;
              common_drive  <= COMMONS_OFF;
              scan_position <= '0;
            end
          end
          OP_VOLT: begin
            digit_codes[0] <= fmt_codes.hi;
            digit_codes[1] <= fmt_codes.mid;
            digit_codes[2] <= fmt_codes.lo;
          end
          OP_AMP: begin
            digit_codes[3] <= fmt_codes.hi;
            digit_codes[4] <= fmt_codes.mid;
            digit_codes[5] <= fmt_codes.lo;
          end
          default: begin
            // Unused code: the result repeats the present drive
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mssd_checker.sv =====
`default_nettype none

module mssd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // At most one common is pulled low
  a_one_common: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[13:8]) >= 5)
    else $error("more than one common driven");

  // With all commons off the segments are dark
  a_dark_when_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[13:8] == 6'h3f) |-> (m_tdata[7:0] == 8'h00))
    else $error("segments lit with all commons off");

  // Input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a pending result");

endmodule

bind meter_seven_segment_scan_display mssd_checker u_mssd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/meter_display_checker.sv =====
`timescale 1ns / 100ps

// Tracks both stream channels of the display driver. Each accepted input is
// applied to a local copy of the display state, and the resulting drive is queued.
// Each accepted output is compared with the oldest queued drive.
module meter_display_checker
  import mssd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [MEAS_W-1:0] s_tdata,
  input  logic [OP_W-1:0]   s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [15:0]       m_tdata,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [COM_W-1:0] com;
  } drive_t;

  drive_t           pending_drives[$];
  code_t            shadow_codes [DIGIT_COUNT];
  logic [POS_W-1:0] shadow_pos;
  logic [SEG_W-1:0] shadow_seg;
  logic [COM_W-1:0] shadow_com;

  function automatic logic [SEG_W-1:0] glyph(input code_t code);
    logic [SEG_W-1:0] g;
    code_t            digit;
    digit = (code >= DP_CODE_OFFSET) ? code - DP_CODE_OFFSET : code;
    case (digit)
      5'd0:    g = 8'h3f;
      5'd1:    g = 8'h06;
      5'd2:    g = 8'h5b;
      5'd3:    g = 8'h4f;
      5'd4:    g = 8'h66;
      5'd5:    g = 8'h6d;
      5'd6:    g = 8'h7d;
      5'd7:    g = 8'h07;
      5'd8:    g = 8'h7f;
      5'd9:    g = 8'h6f;
      default: g = '0;
    endcase
    if (code >= 5'd20) g = '0;
    else if (code >= DP_CODE_OFFSET) g[SEG_W-1] = 1'b1;
    return g;
  endfunction

  // Round to tens of mV; switch to xx.x once the rounded value reaches 10.00 V, with the coarse round-up
  function automatic void show_volts(input logic [MEAS_W-1:0] mv);
    int unsigned t;
    t = ((mv > VOLT_MAX_MV) ? VOLT_MAX_MV : mv);
    t = (t + 5) / 10;
    if (t < 1000) begin
      shadow_codes[0] = code_t'(t / 100 % 10) + DP_CODE_OFFSET;
      shadow_codes[1] = code_t'(t / 10 % 10);
      shadow_codes[2] = code_t'(t % 10);
    end else begin
      if (t % 10 > 5) t = t + 10;
      shadow_codes[0] = code_t'(t / 1000 % 10);
      shadow_codes[1] = code_t'(t / 100 % 10) + DP_CODE_OFFSET;
      shadow_codes[2] = code_t'(t / 10 % 10);
    end
  endfunction

  function automatic void show_amps(input logic [MEAS_W-1:0] ma);
    int unsigned t;
    t = ((ma > AMP_MAX_MA) ? AMP_MAX_MA : ma);
    t = (t + 5) / 10;
    shadow_codes[3] = code_t'(t / 100 % 10) + DP_CODE_OFFSET;
    shadow_codes[4] = code_t'(t / 10 % 10);
    shadow_codes[5] = code_t'(t % 10);
  endfunction

  function automatic void advance_display(input logic [OP_W-1:0] op,
                                          input logic [MEAS_W-1:0] meas);
    drive_t d;
    case (op)
      OP_TICK: begin
        shadow_com = COMMONS_OFF;
        if (shadow_pos < DIGIT_COUNT) begin
          shadow_seg = glyph(shadow_codes[shadow_pos]);
          shadow_com = COMMONS_OFF & ~(COM_W'(1) << shadow_pos);
          shadow_pos = (shadow_pos == LAST_POS) ? '0 : shadow_pos + 1'b1;
        end else begin
          shadow_seg = '0;
          shadow_pos = '0;
        end
      end
      OP_VOLT: show_volts(meas);
      OP_AMP:  show_amps(meas);
      default: ;
    endcase
    d.seg = shadow_seg;
    d.com = shadow_com;
    pending_drives.push_back(d);
  endfunction

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      pending_drives.delete();
      foreach (shadow_codes[i]) shadow_codes[i] = '0;
      shadow_pos  = '0;
      shadow_seg  = '0;
      shadow_com  = COMMONS_OFF;
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (s_tvalid && s_tready) advance_display(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_drives.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected drive tdata %04h", $time, m_tdata);
        end else begin
          want = pending_drives.pop_front();
          if (m_tdata[SEG_W-1:0] !== want.seg ||
              m_tdata[SEG_W+COM_W-1:SEG_W] !== want.com ||
              m_tdata[15:SEG_W+COM_W] !== '0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: drive mismatch: expected seg %02h com %02h, got seg %02h com %02h pad %0b",
                       $time, want.seg, want.com, m_tdata[SEG_W-1:0],
                       m_tdata[SEG_W+COM_W-1:SEG_W], m_tdata[15:SEG_W+COM_W]);
          end
        end
      end
      outstanding = pending_drives.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mssd_pkg::*;

  // Operation code that leaves the display state unchanged; the block still returns a result
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [MEAS_W-1:0] s_tdata;   // [15:0] measurement
  logic [OP_W-1:0]   s_tuser;   // [1:0] operation
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;   // [7:0] segment_lines, [13:8] common_lines
  int                mismatches;
  int                outstanding;
  int unsigned       gap_span;

  meter_seven_segment_scan_display uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  meter_display_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold valid low for a random gap, then present one transaction and
  // wait for the edge that takes it. With a zero gap valid stays high.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [MEAS_W-1:0] meas);
    int unsigned gap;
    gap = $urandom_range(0, gap_span);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= meas;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly in-range values, some near the rounding and saturation edges,
  // some over the whole 16-bit field so every bit toggles.
  function automatic logic [MEAS_W-1:0] pick_measurement(input logic [OP_W-1:0] op);
    logic [MEAS_W-1:0] cap;
    cap = (op == OP_AMP) ? AMP_MAX_MA : VOLT_MAX_MV;
    case ($urandom_range(0, 9))
      0, 1:    return MEAS_W'($urandom);
      2:       return cap - 16'd10 + MEAS_W'($urandom_range(0, 20));
      3:       return (op == OP_AMP) ? MEAS_W'($urandom_range(985, 1015))
                                     : MEAS_W'($urandom_range(9980, 10070));
      default: return MEAS_W'($urandom_range(0, cap));
    endcase
  endfunction

  function automatic int unsigned pick_span();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 16;
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [OP_W-1:0] op;
    int unsigned     r;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_TICK;
    gap_span = 16;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset pattern, range extremes, saturation, both voltage
    // formats, the coarse round-up and an unused operation code.
    send_item(OP_TICK, 16'd0);
    send_item(OP_VOLT, 16'd0);
    send_item(OP_VOLT, 16'hffff);
    send_item(OP_AMP,  16'hffff);
    repeat (DIGIT_COUNT) send_item(OP_TICK, 16'hffff);
    send_item(OP_VOLT, 16'd10055);
    send_item(OP_VOLT, 16'd9995);
    send_item(OP_VOLT, 16'd994);
    send_item(OP_AMP,  16'd2994);
    send_item(OP_AMP,  16'd5);
    send_item(OP_UNUSED, 16'hffff);
    send_item(OP_VOLT, 16'd34501);
    send_item(OP_AMP,  16'd3001);
    repeat (DIGIT_COUNT) send_item(OP_TICK, 16'd0);
    send_item(OP_VOLT, 16'd10050);

    // Random: ticks dominate so the scan shows each update
    for (int n = 0; n < 1200; n++) begin
      if (n % 60 == 0) gap_span = pick_span();
      r = $urandom_range(0, 19);
      if (r < 9)       op = OP_TICK;
      else if (r < 14) op = OP_VOLT;
      else if (r < 19) op = OP_AMP;
      else             op = OP_UNUSED;
      send_item(op, (op == OP_TICK || op == OP_UNUSED) ? MEAS_W'($urandom) :
                                                         pick_measurement(op));
    end
    s_tvalid <= 1'b0;

    // Let the checker log the last transaction, drain, then allow the
    // two-stage pipeline to settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[meter_seven_segment_scan_display] OK");
    else
      $display("[meter_seven_segment_scan_display] ERROR");
    $finish;
  end

  // Result side: stall ready at random, with stretches of no stall
  initial begin
    int unsigned stall;
    int unsigned stall_span;
    int unsigned taken;
    m_tready   <= 1'b0;
    stall_span = 16;
    taken      = 0;
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) stall_span = pick_span();
      stall = $urandom_range(0, stall_span);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[meter_seven_segment_scan_display] ERROR");
    $finish;
  end

endmodule
